@@ rtl/svpwm_pkg.sv @@
`default_nettype none

package svpwm_pkg;

    localparam int PHASE_W    = 10;
    localparam int SLEW_W     = 16;
    localparam int CHAN_W     = 2;
    localparam int TDUTY_W    = 10;
    localparam int PINS_OUT_W = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [PHASE_W-1:0] PERIOD_TOP_RST    = 10'd999;
    localparam logic [SLEW_W-1:0]  SLEW_INTERVAL_RST = 16'd2500;
    localparam int                 DUTY_RST_HIGH     = 75;
    localparam int                 DUTY_RST_LOW      = 70;
    localparam int                 DUTY_HIGH_CHANS   = 2;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    typedef enum logic [0:0] {
        REG_PERIOD_TOP    = 1'b0,
        REG_SLEW_INTERVAL = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [PHASE_W-1:0] period_top;
        logic [SLEW_W-1:0]  slew_interval;
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/svpwm_in_if.sv @@
`default_nettype none

interface svpwm_in_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [svpwm_pkg::CHAN_W-1:0]     channel;
    logic [svpwm_pkg::TDUTY_W-1:0]    target_duty;

    modport source (output valid, cmd, channel, target_duty, input ready);
    modport sink   (input valid, cmd, channel, target_duty, output ready);
endinterface

`default_nettype wire

@@ rtl/svpwm_out_if.sv @@
`default_nettype none

interface svpwm_out_if;
    logic                                valid;
    logic                                ready;
    logic [svpwm_pkg::PINS_OUT_W-1:0]    pin_levels;
    logic                                ramping;

    modport source (output valid, pin_levels, ramping, input ready);
    modport sink   (input valid, pin_levels, ramping, output ready);
endinterface

`default_nettype wire

@@ rtl/servo_pwm_with_slew_unit.sv @@
`default_nettype none

// Multichannel servo PWM with slewed duty. Each item is either a timer tick,
// which advances the shared phase, updates the pin levels and every
// slew_interval ticks moves each duty one unit toward its target, or a set
// command that loads one channel's target. The block takes one item per
// clock cycle: all state updates in a single pass between the input transfer
// and the result register, so each result appears in the cycle after its item
// and item.ready stays high whenever the result register is empty or being
// taken. pin_levels shows channels 0 to 3; ramping is high while any
// channel's duty differs from its target.

module servo_pwm_with_slew_unit #(
    parameter int CHANNELS  = 4,
    parameter int DUTY_BITS = 10
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [svpwm_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [svpwm_pkg::APB_DATA_W-1:0]    pwdata,
    output      logic [svpwm_pkg::APB_DATA_W-1:0]    prdata,
    output      logic                                pready,
    svpwm_in_if.sink                                 item,
    svpwm_out_if.source                              result
);

    localparam int PW    = svpwm_pkg::PHASE_W;
    localparam int SW    = svpwm_pkg::SLEW_W;
    localparam int CMP_W = ((DUTY_BITS > PW) ? DUTY_BITS : PW) + 1;

    svpwm_pkg::cfg_t cfg;

    logic [PW-1:0]                  phase_reg, phase_next;
    logic [CHANNELS-1:0]            pins_reg, pins_next;
    logic [DUTY_BITS-1:0]           duty_reg   [CHANNELS];
    logic [DUTY_BITS-1:0]           duty_next  [CHANNELS];
    logic [DUTY_BITS-1:0]           target_reg [CHANNELS];
    logic [DUTY_BITS-1:0]           target_next[CHANNELS];
    logic [SW-1:0]                  slew_count_reg, slew_count_next;
    logic                           out_valid_reg, out_valid_next;
    logic [svpwm_pkg::PINS_OUT_W-1:0] pin_levels_reg, pin_view;
    logic                           ramping_reg, ramping_next;

    logic [PW:0]                    phase_inc;
    logic [SW-1:0]                  slew_inc;
    logic                           slew_step;
    logic                           wrap;
    logic                           in_xfer;
    logic                           is_tick;

    svpwm_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign item.ready = !out_valid_reg || result.ready;
    assign in_xfer    = item.valid && item.ready;
    assign is_tick    = (item.cmd == svpwm_pkg::CMD_TICK);

    assign phase_inc = {1'b0, phase_reg} + (PW+1)'(1);
    assign slew_inc  = slew_count_reg + SW'(1);
    assign slew_step = (slew_inc >= cfg.slew_interval);
    assign wrap      = (phase_inc > {1'b0, cfg.period_top});

    always_comb
    begin
        phase_next      = phase_reg;
        pins_next       = pins_reg;
        slew_count_next = slew_count_reg;
        duty_next       = duty_reg;
        target_next     = target_reg;
        if (in_xfer)
        begin
            if (is_tick)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (CMP_W'(phase_inc) > CMP_W'(duty_reg[i]))
                    begin
                        pins_next[i] = 1'b0;
                    end
                end
                if (wrap)
                begin
                    pins_next  = '1;
                    phase_next = '0;
                end
                else
                begin
                    phase_next = phase_inc[PW-1:0];
                end
                if (slew_step)
                begin
                    slew_count_next = '0;
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (duty_reg[i] < target_reg[i])
                        begin
                            duty_next[i] = duty_reg[i] + DUTY_BITS'(1);
                        end
                        else if (duty_reg[i] > target_reg[i])
                        begin
                            duty_next[i] = duty_reg[i] - DUTY_BITS'(1);
                        end
                    end
                end
                else
                begin
                    slew_count_next = slew_inc;
                end
            end
            else
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (int'(item.channel) == i)
                    begin
                        target_next[i] = DUTY_BITS'(item.target_duty);
                    end
                end
            end
        end
    end

    always_comb
    begin
        ramping_next = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (duty_next[i] != target_next[i])
            begin
                ramping_next = 1'b1;
            end
        end
    end

    for (genvar j = 0; j < svpwm_pkg::PINS_OUT_W; j++)
    begin : g_pin_view
        if (j < CHANNELS)
        begin : g_on
            assign pin_view[j] = pins_next[j];
        end
        else
        begin : g_off
            assign pin_view[j] = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_xfer)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= '0;
            pins_reg       <= '0;
            slew_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (i < svpwm_pkg::DUTY_HIGH_CHANS)
                begin
                    duty_reg[i]   <= DUTY_BITS'(svpwm_pkg::DUTY_RST_HIGH);
                    target_reg[i] <= DUTY_BITS'(svpwm_pkg::DUTY_RST_HIGH);
                end
                else
                begin
                    duty_reg[i]   <= DUTY_BITS'(svpwm_pkg::DUTY_RST_LOW);
                    target_reg[i] <= DUTY_BITS'(svpwm_pkg::DUTY_RST_LOW);
                end
            end
        end
        else
        begin
            phase_reg      <= phase_next;
            pins_reg       <= pins_next;
            slew_count_reg <= slew_count_next;
            duty_reg       <= duty_next;
            target_reg     <= target_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pin_levels_reg <= pin_view;
            ramping_reg    <= ramping_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.pin_levels = pin_levels_reg;
    assign result.ramping    = ramping_reg;

    a_set_holds_pins: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !is_tick |=> $stable(pins_reg) && $stable(phase_reg))
        else $error("set transfer changed pins or phase");

    a_wrap_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && is_tick && wrap |=> (phase_reg == '0) && (&pins_reg))
        else $error("period wrap did not restart phase and raise pins");

    a_slew_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && is_tick && slew_step |=> (slew_count_reg == '0))
        else $error("slew step did not clear slew count");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_xfer))
        else $error("result valid without input transfer");

endmodule

`default_nettype wire

@@ rtl/svpwm_apb.sv @@
`default_nettype none

module svpwm_apb (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [svpwm_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [svpwm_pkg::APB_DATA_W-1:0]    pwdata,
    output      logic [svpwm_pkg::APB_DATA_W-1:0]    prdata,
    output      logic                                pready,
    output      svpwm_pkg::cfg_t                     cfg
);

    svpwm_pkg::cfg_t     cfg_reg;
    svpwm_pkg::cfg_t     cfg_next;
    svpwm_pkg::reg_idx_t reg_idx;
    logic                wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = svpwm_pkg::reg_idx_t'(paddr[2]);
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                svpwm_pkg::REG_PERIOD_TOP:
                    cfg_next.period_top = pwdata[svpwm_pkg::PHASE_W-1:0];
                svpwm_pkg::REG_SLEW_INTERVAL:
                    cfg_next.slew_interval = pwdata[svpwm_pkg::SLEW_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            svpwm_pkg::REG_PERIOD_TOP:
                prdata = svpwm_pkg::APB_DATA_W'(cfg_reg.period_top);
            svpwm_pkg::REG_SLEW_INTERVAL:
                prdata = svpwm_pkg::APB_DATA_W'(cfg_reg.slew_interval);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_top    <= svpwm_pkg::PERIOD_TOP_RST;
            cfg_reg.slew_interval <= svpwm_pkg::SLEW_INTERVAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ bench/tb_servo_pwm_with_slew_unit.sv @@
`timescale 1ns / 1ps

module tb_servo_pwm_with_slew_unit;

    localparam int N_CH        = 4;
    localparam int DIR_ROWS    = 30;
    localparam int N_PHASES    = 6;
    localparam int HOLD_AT     = 700;
    localparam int HOLD_LEN    = 250;
    localparam int SETTLE_CYC  = 4;
    localparam int CYCLE_LIMIT = 300000;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;
    typedef enum logic [1:0] { RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE } rx_mode_t;

    typedef struct packed {
        logic [svpwm_pkg::PINS_OUT_W-1:0] pins;
        logic                             ramp;
    } pwm_levels_t;

    typedef struct packed {
        row_kind_t                        kind;
        logic                             cmd;
        logic [svpwm_pkg::CHAN_W-1:0]     channel;
        svpwm_pkg::reg_idx_t              reg_sel;
        logic [svpwm_pkg::APB_DATA_W-1:0] value;
        logic                             known;
        pwm_levels_t                      levels;
    } script_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [svpwm_pkg::APB_ADDR_W-1:0] paddr;
    logic [svpwm_pkg::APB_DATA_W-1:0] pwdata;
    logic [svpwm_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;

    svpwm_in_if  item_if ();
    svpwm_out_if result_if ();

    servo_pwm_with_slew_unit #(
        .CHANNELS  (N_CH),
        .DUTY_BITS (svpwm_pkg::TDUTY_W)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_if.sink),
        .result  (result_if.source)
    );

    logic [svpwm_pkg::PHASE_W-1:0] cfg_top;
    logic [svpwm_pkg::SLEW_W-1:0]  cfg_slew;
    logic [svpwm_pkg::PHASE_W-1:0] servo_phase;
    logic [N_CH-1:0]               servo_pins;
    logic [svpwm_pkg::TDUTY_W-1:0] servo_duty   [N_CH];
    logic [svpwm_pkg::TDUTY_W-1:0] servo_target [N_CH];
    logic [svpwm_pkg::SLEW_W-1:0]  slew_ticks;

    pwm_levels_t level_q [$];
    logic        known_on;
    pwm_levels_t known_levels;

    script_row_t script [DIR_ROWS];
    int unsigned ph_top   [N_PHASES] = '{20, 5, 63, 1023, 1, 0};
    int unsigned ph_slew  [N_PHASES] = '{3, 1, 7, 65535, 2, 0};
    int          ph_items [N_PHASES] = '{350, 250, 300, 150, 200, 250};

    int       errors       = 0;
    int       results_seen = 0;
    int       cycle_count  = 0;
    int       burst_left   = 0;
    int       hold_left    = 0;
    bit       hold_done    = 1'b0;
    int       mode_left    = 0;
    rx_mode_t rx_mode      = RX_OPEN;

    always #1 clk = ~clk;

    function automatic void servo_reset();
        cfg_top     = svpwm_pkg::PERIOD_TOP_RST;
        cfg_slew    = svpwm_pkg::SLEW_INTERVAL_RST;
        servo_phase = '0;
        servo_pins  = '0;
        slew_ticks  = '0;
        for (int i = 0; i < N_CH; i++)
        begin
            servo_duty[i]   = (i < svpwm_pkg::DUTY_HIGH_CHANS)
                              ? svpwm_pkg::TDUTY_W'(svpwm_pkg::DUTY_RST_HIGH)
                              : svpwm_pkg::TDUTY_W'(svpwm_pkg::DUTY_RST_LOW);
            servo_target[i] = servo_duty[i];
        end
    endfunction

    function automatic pwm_levels_t servo_step(logic c, logic [svpwm_pkg::CHAN_W-1:0] ch,
                                               logic [svpwm_pkg::TDUTY_W-1:0] td);
        logic [svpwm_pkg::PHASE_W:0] nxt;
        pwm_levels_t                 lv;
        if (c == svpwm_pkg::CMD_TICK)
        begin
            nxt = {1'b0, servo_phase} + 1'b1;
            for (int i = 0; i < N_CH; i++)
                if (nxt > servo_duty[i])
                    servo_pins[i] = 1'b0;
            if (nxt > cfg_top)
            begin
                servo_pins  = '1;
                servo_phase = '0;
            end
            else
                servo_phase = nxt[svpwm_pkg::PHASE_W-1:0];
            // duty steps come after the pin compare of this tick
            slew_ticks = slew_ticks + 1'b1;
            if (slew_ticks >= cfg_slew)
            begin
                slew_ticks = '0;
                for (int i = 0; i < N_CH; i++)
                begin
                    if (servo_duty[i] < servo_target[i])
                        servo_duty[i] = servo_duty[i] + 1'b1;
                    else if (servo_duty[i] > servo_target[i])
                        servo_duty[i] = servo_duty[i] - 1'b1;
                end
            end
        end
        else if (int'(ch) < N_CH)
            servo_target[ch] = td;
        lv.pins = servo_pins[svpwm_pkg::PINS_OUT_W-1:0];
        lv.ramp = 1'b0;
        for (int i = 0; i < N_CH; i++)
            if (servo_duty[i] != servo_target[i])
                lv.ramp = 1'b1;
        return lv;
    endfunction

    function automatic script_row_t row_item(logic c, logic [svpwm_pkg::CHAN_W-1:0] ch,
                                             logic [svpwm_pkg::TDUTY_W-1:0] td);
        script_row_t r;
        r         = '0;
        r.kind    = ROW_ITEM;
        r.cmd     = c;
        r.channel = ch;
        r.value   = svpwm_pkg::APB_DATA_W'(td);
        return r;
    endfunction

    function automatic script_row_t row_known(logic c, logic [svpwm_pkg::CHAN_W-1:0] ch,
                                              logic [svpwm_pkg::TDUTY_W-1:0] td,
                                              logic [svpwm_pkg::PINS_OUT_W-1:0] pins,
                                              logic ramp);
        script_row_t r;
        r             = row_item(c, ch, td);
        r.known       = 1'b1;
        r.levels.pins = pins;
        r.levels.ramp = ramp;
        return r;
    endfunction

    function automatic script_row_t row_cfg(svpwm_pkg::reg_idx_t idx,
                                            logic [svpwm_pkg::APB_DATA_W-1:0] v);
        script_row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_sel = idx;
        r.value   = v;
        return r;
    endfunction

    task automatic put_item(logic c, logic [svpwm_pkg::CHAN_W-1:0] ch,
                            logic [svpwm_pkg::TDUTY_W-1:0] td,
                            logic known, pwm_levels_t lv);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        item_if.valid       <= 1'b1;
        item_if.cmd         <= c;
        item_if.channel     <= ch;
        item_if.target_duty <= td;
        known_on     = known;
        known_levels = lv;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic settle();
        item_if.valid <= 1'b0;
        while (level_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic reg_write(svpwm_pkg::reg_idx_t idx,
                             logic [svpwm_pkg::APB_DATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= svpwm_pkg::APB_ADDR_W'(4 * int'(idx));
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == svpwm_pkg::REG_PERIOD_TOP)
            cfg_top = val[svpwm_pkg::PHASE_W-1:0];
        else
            cfg_slew = val[svpwm_pkg::SLEW_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        pwm_levels_t want;
        if (rst_n && item_if.valid && item_if.ready)
        begin
            want = servo_step(item_if.cmd, item_if.channel, item_if.target_duty);
            if (known_on)
                want = known_levels;
            level_q.push_back(want);
        end
        if (rst_n && result_if.valid && result_if.ready)
        begin
            results_seen++;
            if (level_q.size() == 0)
            begin
                $display("%0t: unexpected transfer: pin_levels %h ramping %b",
                         $time, result_if.pin_levels, result_if.ramping);
                errors++;
            end
            else
            begin
                want = level_q.pop_front();
                if (result_if.pin_levels !== want.pins)
                begin
                    $display("%0t: pin_levels expected %h actual %h",
                             $time, want.pins, result_if.pin_levels);
                    errors++;
                end
                if (result_if.ramping !== want.ramp)
                begin
                    $display("%0t: ramping expected %b actual %b",
                             $time, want.ramp, result_if.ramping);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else
        begin
            // hold ready low for a long stretch so the block backs up
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:   result_if.ready <= 1'b1;
                    RX_COIN:   result_if.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: result_if.ready <= ($urandom_range(0, 3) == 0);
                    default:   result_if.ready <= ~result_if.ready;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        script_row_t                   row;
        logic                          c;
        logic [svpwm_pkg::CHAN_W-1:0]  ch;
        logic [svpwm_pkg::TDUTY_W-1:0] td;
        logic [svpwm_pkg::PHASE_W-1:0] top;
        logic [svpwm_pkg::SLEW_W-1:0]  iv;
        int                            near;
        int                            span;

        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        item_if.valid        = 1'b0;
        item_if.cmd          = svpwm_pkg::CMD_TICK;
        item_if.channel      = '0;
        item_if.target_duty  = '0;
        result_if.ready      = 1'b0;
        known_on             = 1'b0;
        known_levels         = '0;
        servo_reset();

        script = '{
            row_known(svpwm_pkg::CMD_TICK, 2'd0, 10'd0,    4'h0, 1'b0),
            row_known(svpwm_pkg::CMD_SET,  2'd0, 10'd1023, 4'h0, 1'b1),
            row_known(svpwm_pkg::CMD_SET,  2'd0, 10'd75,   4'h0, 1'b0),
            row_known(svpwm_pkg::CMD_SET,  2'd3, 10'd0,    4'h0, 1'b1),
            row_known(svpwm_pkg::CMD_SET,  2'd3, 10'd70,   4'h0, 1'b0),
            row_item(svpwm_pkg::CMD_TICK, 2'd1, 10'd1023),
            row_item(svpwm_pkg::CMD_TICK, 2'd2, 10'd0),
            row_item(svpwm_pkg::CMD_TICK, 2'd3, 10'd1023),
            // lower the top below the running phase
            row_cfg(svpwm_pkg::REG_PERIOD_TOP, 32'd2),
            row_known(svpwm_pkg::CMD_TICK, 2'd0, 10'd0,    4'hF, 1'b0),
            row_cfg(svpwm_pkg::REG_SLEW_INTERVAL, 32'd0),
            row_item(svpwm_pkg::CMD_SET,  2'd1, 10'd0),
            row_item(svpwm_pkg::CMD_SET,  2'd2, 10'd1023),
            row_item(svpwm_pkg::CMD_TICK, 2'd1, 10'd512),
            row_item(svpwm_pkg::CMD_TICK, 2'd2, 10'd341),
            row_item(svpwm_pkg::CMD_TICK, 2'd3, 10'd682),
            row_cfg(svpwm_pkg::REG_PERIOD_TOP, 32'd0),
            row_item(svpwm_pkg::CMD_TICK, 2'd0, 10'd0),
            row_item(svpwm_pkg::CMD_TICK, 2'd3, 10'd1023),
            row_cfg(svpwm_pkg::REG_SLEW_INTERVAL, 32'd1),
            row_cfg(svpwm_pkg::REG_PERIOD_TOP, 32'd1023),
            row_item(svpwm_pkg::CMD_SET,  2'd0, 10'd0),
            row_item(svpwm_pkg::CMD_SET,  2'd1, 10'd75),
            row_item(svpwm_pkg::CMD_SET,  2'd2, 10'd70),
            row_item(svpwm_pkg::CMD_SET,  2'd3, 10'd1023),
            row_item(svpwm_pkg::CMD_TICK, 2'd0, 10'd0),
            row_item(svpwm_pkg::CMD_TICK, 2'd1, 10'd1023),
            row_item(svpwm_pkg::CMD_TICK, 2'd2, 10'd0),
            row_cfg(svpwm_pkg::REG_SLEW_INTERVAL, 32'd65535),
            row_item(svpwm_pkg::CMD_TICK, 2'd3, 10'd1023)
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i])
        begin
            row = script[i];
            if (row.kind == ROW_CFG)
            begin
                settle();
                reg_write(row.reg_sel, row.value);
            end
            else
                put_item(row.cmd, row.channel, row.value[svpwm_pkg::TDUTY_W-1:0],
                         row.known, row.levels);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            top = (ph == N_PHASES - 1) ? svpwm_pkg::PHASE_W'($urandom_range(1, 100))
                                       : svpwm_pkg::PHASE_W'(ph_top[ph]);
            iv  = (ph == N_PHASES - 1) ? svpwm_pkg::SLEW_W'($urandom_range(1, 10))
                                       : svpwm_pkg::SLEW_W'(ph_slew[ph]);
            settle();
            reg_write(svpwm_pkg::REG_PERIOD_TOP, svpwm_pkg::APB_DATA_W'(top));
            reg_write(svpwm_pkg::REG_SLEW_INTERVAL, svpwm_pkg::APB_DATA_W'(iv));
            repeat (ph_items[ph])
            begin
                c  = ($urandom_range(0, 4) == 0) ? svpwm_pkg::CMD_SET : svpwm_pkg::CMD_TICK;
                ch = svpwm_pkg::CHAN_W'($urandom_range(0, 3));
                span = (int'(cfg_top) + 2 > 1023) ? 1023 : int'(cfg_top) + 2;
                case ($urandom_range(0, 9))
                    0: td = '0;
                    1: td = '1;
                    2, 3, 4, 5:
                    begin
                        near = int'(servo_duty[ch]) + int'($urandom_range(0, 8)) - 4;
                        if (near < 0)
                            near = 0;
                        if (near > 1023)
                            near = 1023;
                        td = svpwm_pkg::TDUTY_W'(near);
                    end
                    6, 7, 8: td = svpwm_pkg::TDUTY_W'($urandom_range(0, span));
                    default: td = svpwm_pkg::TDUTY_W'($urandom);
                endcase
                put_item(c, ch, td, 1'b0, '0);
            end
        end

        settle();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
